>>> src/gdr_pkg.sv
`timescale 1ns / 1ps
package gdr_pkg;

  localparam int MAP_BITS  = 6;
  localparam int MAP_DIM   = 1 << MAP_BITS;
  localparam int MAP_AW    = 2 * MAP_BITS;
  localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
  localparam int FRAC_BITS = 16;

  localparam int RAY_W   = 34;
  localparam int DELTA_W = 40;
  localparam int SIDE_W  = 49;
  localparam int DIV_NW  = 40;
  localparam int DIV_DW  = 34;
  localparam int DIV_CW  = 6;

  localparam logic [7:0]  WALL_LIMIT = 8'd48;
  localparam logic [7:0]  STEP_LIMIT = 8'(2 * MAP_DIM + 2);
  localparam logic [23:0] PERP_SAT   = 24'hFFFFFF;
  localparam logic [15:0] LH_SAT     = 16'hFFFF;
  localparam logic [DELTA_W-1:0] DELTA_SAT = {DELTA_W{1'b1}};

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [2:0] REG_PLAYER_X       = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y       = 3'd1;
  localparam logic [2:0] REG_FACING_X       = 3'd2;
  localparam logic [2:0] REG_FACING_Y       = 3'd3;
  localparam logic [2:0] REG_CAMERA_PLANE_X = 3'd4;
  localparam logic [2:0] REG_CAMERA_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd6;
  localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd7;

  typedef struct packed {
    logic        command;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic [7:0]  cell_value;
    logic [10:0] column;
  } cmd_t;

  typedef struct packed {
    logic [10:0] out_column;
    logic [23:0] perp_distance;
    logic [15:0] line_height;
    logic [10:0] wall_top;
    logic [10:0] wall_bottom;
    logic        hit_side;
    logic [7:0]  hit_cell;
    logic [15:0] wall_fraction;
    logic        escaped;
  } res_t;

  typedef struct packed {
    logic        valid;
    cmd_t        item;
  } qhead_t;

  typedef struct packed {
    logic [21:0]        player_x;
    logic [21:0]        player_y;
    logic signed [17:0] facing_x;
    logic signed [17:0] facing_y;
    logic signed [17:0] camera_plane_x;
    logic signed [17:0] camera_plane_y;
    logic [11:0]        screen_width;
    logic [11:0]        screen_height;
  } cfg_t;

endpackage

>>> src/gdr_ram.sv
`timescale 1ns / 1ps
module gdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/gdr_divider.sv
`timescale 1ns / 1ps
module gdr_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gdr_pkg::DIV_NW-1:0] num,
  input  logic [gdr_pkg::DIV_DW-1:0] den,
  output logic                       done,
  output logic [gdr_pkg::DIV_NW-1:0] quot
);
  import gdr_pkg::*;

  logic [DIV_NW-1:0] acc;
  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dsr;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign trial = {rem, acc[DIV_NW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};
  assign quot  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc  <= num;
        dsr  <= den;
        rem  <= '0;
        cnt  <= DIV_CW'(DIV_NW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        acc <= {acc[DIV_NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> src/gdr_front.sv
`timescale 1ns / 1ps
module gdr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  gdr_pkg::cmd_t   cmd,
  input  logic            back_ready,
  input  logic            pop,
  output gdr_pkg::qhead_t head
);
  import gdr_pkg::*;

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  assign cmd_stall  = (count == 2'd2) || !back_ready;
  assign push       = cmd_valid && !cmd_stall;
  assign head       = {(count != 2'd0), slots[rptr]};

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        slots[wptr] <= cmd;
        wptr        <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> src/gdr_back.sv
`timescale 1ns / 1ps
module gdr_back (
  input  logic            clk,
  input  logic            rst,
  input  gdr_pkg::cfg_t   cfg,
  input  gdr_pkg::qhead_t head,
  output logic            pop,
  output logic            ready,
  output logic            res_valid,
  input  logic            res_stall,
  output gdr_pkg::res_t   res
);
  import gdr_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CAM, S_RAYMUL, S_RAYSUM, S_DELX_GO, S_DELX, S_DELY_GO, S_DELY,
    S_SIDEX, S_SIDEY, S_STEP, S_EVAL, S_PERP_GO, S_PERP, S_LH_GO, S_LH, S_WALL,
    S_FRAC, S_FIN
  } state_t;

  localparam logic signed [29:0] CAM_ONE   = 30'sd1 <<< FRAC_BITS;
  localparam logic signed [7:0]  COORD_MAX = 8'(MAP_DIM - 1);

  state_t                    state;
  logic [MAP_AW-1:0]         clr_addr;
  logic [10:0]               column;
  logic signed [29:0]        cam;
  logic signed [47:0]        prodx, prody;
  logic signed [RAY_W-1:0]   rx, ry;
  logic [DELTA_W-1:0]        dx, dy;
  logic [40:0]               phix, phiy;
  logic [32:0]               plox, ploy;
  logic [SIDE_W-1:0]         sx, sy;
  logic signed [7:0]         mx, my;
  logic                      side;
  logic [7:0]                n;
  logic [7:0]                hit_byte;
  logic                      esc;
  logic [23:0]               perp;
  logic [15:0]               lh;
  logic [15:0]               frac;
  logic [31:0]               wprod;
  logic                      div_start;
  logic [DIV_NW-1:0]         div_num;
  logic [DIV_DW-1:0]         div_den;
  logic                      div_done;
  logic [DIV_NW-1:0]         div_quot;

  logic                      ram_we;
  logic [MAP_AW-1:0]         ram_waddr;
  logic [7:0]                ram_wdata;
  logic [MAP_AW-1:0]         ram_raddr;
  logic [7:0]                ram_rdata;

  logic [11:0]               w_eff, h_eff;
  logic [RAY_W-1:0]          magx, magy, magr;
  logic [16:0]               distx, disty;
  logic                      take_x;
  logic signed [7:0]         nmx, nmy;
  logic signed [25:0]        num_s;
  logic [25:0]               num_mag;
  logic signed [RAY_W-1:0]   r_sel, r_oth;
  logic [15:0]               p_oth;
  logic [10:0]               half_h;
  logic [16:0]               lh_up;
  logic [16:0]               de_sum;
  logic [10:0]               ds_v, de_v;
  logic [11:0]               h_m1;
  logic                      out_free;

  function automatic logic [RAY_W-1:0] mag(input logic signed [RAY_W-1:0] v);
    mag = v[RAY_W-1] ? RAY_W'(-v) : RAY_W'(v);
  endfunction

  assign w_eff = (cfg.screen_width == 12'd0) ? 12'd1 : cfg.screen_width;
  assign h_eff = (cfg.screen_height == 12'd0) ? 12'd1 : cfg.screen_height;
  assign magx  = mag(rx);
  assign magy  = mag(ry);
  assign distx = rx[RAY_W-1] ? {1'b0, cfg.player_x[15:0]}
                             : 17'h10000 - {1'b0, cfg.player_x[15:0]};
  assign disty = ry[RAY_W-1] ? {1'b0, cfg.player_y[15:0]}
                             : 17'h10000 - {1'b0, cfg.player_y[15:0]};

  assign take_x = sx < sy;
  assign nmx = take_x ? (rx[RAY_W-1] ? mx - 8'sd1 : mx + 8'sd1) : mx;
  assign nmy = take_x ? my : (ry[RAY_W-1] ? my - 8'sd1 : my + 8'sd1);

  always_comb begin
    if (side) begin
      num_s = $signed({{2{my[7]}}, my, 16'b0}) - $signed({4'b0, cfg.player_y})
            + (ry[RAY_W-1] ? 26'sd65536 : 26'sd0);
      r_sel = ry;
      r_oth = rx;
      p_oth = cfg.player_x[15:0];
    end else begin
      num_s = $signed({{2{mx[7]}}, mx, 16'b0}) - $signed({4'b0, cfg.player_x})
            + (rx[RAY_W-1] ? 26'sd65536 : 26'sd0);
      r_sel = rx;
      r_oth = ry;
      p_oth = cfg.player_y[15:0];
    end
  end

  assign num_mag = num_s[25] ? 26'(-num_s) : 26'(num_s);
  assign magr    = mag(r_sel);

  assign half_h = h_eff[11:1];
  assign lh_up  = ({1'b0, lh} + 17'd1) >> 1;
  assign ds_v   = (lh_up > {6'b0, half_h}) ? 11'd0 : half_h - lh_up[10:0];
  assign de_sum = {2'b0, lh[15:1]} + {6'b0, half_h};
  assign h_m1   = h_eff - 12'd1;
  always_comb begin
    if (de_sum >= {5'b0, h_eff}) begin
      de_v = (h_m1 > 12'd2047) ? 11'd2047 : h_m1[10:0];
    end else begin
      de_v = (de_sum > 17'd2047) ? 11'd2047 : de_sum[10:0];
    end
  end

  assign out_free = !(res_valid && res_stall);
  assign ready    = state != S_CLEAR;
  assign pop      = (state == S_IDLE) && head.valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = 8'd0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (pop && head.item.command == CMD_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = {head.item.cell_row, head.item.cell_col};
      ram_wdata = head.item.cell_value;
    end
  end

  assign ram_raddr = {nmy[MAP_BITS-1:0], nmx[MAP_BITS-1:0]};

  gdr_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gdr_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      res_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (res_valid && !res_stall && state != S_FIN) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {MAP_AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head.valid && head.item.command == CMD_CAST) begin
            column    <= head.item.column;
            div_num   <= DIV_NW'({head.item.column, 1'b0, {FRAC_BITS{1'b0}}});
            div_den   <= DIV_DW'(w_eff);
            div_start <= 1'b1;
            state     <= S_CAM;
          end
        end
        S_CAM: begin
          if (div_done) begin
            cam   <= $signed({2'b00, div_quot[27:0]}) - CAM_ONE;
            state <= S_RAYMUL;
          end
        end
        S_RAYMUL: begin
          prodx <= cfg.camera_plane_x * cam;
          prody <= cfg.camera_plane_y * cam;
          state <= S_RAYSUM;
        end
        S_RAYSUM: begin
          rx    <= RAY_W'(cfg.facing_x) + RAY_W'(prodx >>> FRAC_BITS);
          ry    <= RAY_W'(cfg.facing_y) + RAY_W'(prody >>> FRAC_BITS);
          state <= S_DELX_GO;
        end
        S_DELX_GO: begin
          if (magx == '0) begin
            dx    <= DELTA_SAT;
            state <= S_DELY_GO;
          end else begin
            div_num   <= DIV_NW'(1) << (2 * FRAC_BITS);
            div_den   <= DIV_DW'(magx);
            div_start <= 1'b1;
            state     <= S_DELX;
          end
        end
        S_DELX: begin
          if (div_done) begin
            dx    <= DELTA_W'(div_quot);
            state <= S_DELY_GO;
          end
        end
        S_DELY_GO: begin
          if (magy == '0) begin
            dy    <= DELTA_SAT;
            state <= S_SIDEX;
          end else begin
            div_num   <= DIV_NW'(1) << (2 * FRAC_BITS);
            div_den   <= DIV_DW'(magy);
            div_start <= 1'b1;
            state     <= S_DELY;
          end
        end
        S_DELY: begin
          if (div_done) begin
            dy    <= DELTA_W'(div_quot);
            state <= S_SIDEX;
          end
        end
        S_SIDEX: begin
          phix  <= dx[DELTA_W-1:FRAC_BITS] * distx;
          plox  <= dx[FRAC_BITS-1:0] * distx;
          phiy  <= dy[DELTA_W-1:FRAC_BITS] * disty;
          ploy  <= dy[FRAC_BITS-1:0] * disty;
          state <= S_SIDEY;
        end
        S_SIDEY: begin
          sx    <= SIDE_W'(phix) + SIDE_W'(plox >> FRAC_BITS);
          sy    <= SIDE_W'(phiy) + SIDE_W'(ploy >> FRAC_BITS);
          mx    <= $signed({2'b00, cfg.player_x[21:16]});
          my    <= $signed({2'b00, cfg.player_y[21:16]});
          side  <= 1'b0;
          n     <= 8'd0;
          esc   <= 1'b0;
          state <= S_STEP;
        end
        S_STEP: begin
          if (take_x) begin
            sx   <= sx + SIDE_W'(dx);
            side <= 1'b0;
          end else begin
            sy   <= sy + SIDE_W'(dy);
            side <= 1'b1;
          end
          mx    <= nmx;
          my    <= nmy;
          n     <= n + 8'd1;
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (mx < 8'sd0 || mx > COORD_MAX || my < 8'sd0 || my > COORD_MAX
              || (ram_rdata <= WALL_LIMIT && n >= STEP_LIMIT)) begin
            esc      <= 1'b1;
            perp     <= PERP_SAT;
            lh       <= 16'd0;
            hit_byte <= 8'd0;
            frac     <= 16'd0;
            state    <= S_FIN;
          end else if (ram_rdata > WALL_LIMIT) begin
            hit_byte <= ram_rdata;
            state    <= S_PERP_GO;
          end else begin
            state <= S_STEP;
          end
        end
        S_PERP_GO: begin
          if (r_sel == '0) begin
            perp  <= PERP_SAT;
            state <= S_LH_GO;
          end else begin
            div_num   <= {num_mag[23:0], {FRAC_BITS{1'b0}}};
            div_den   <= DIV_DW'(magr);
            div_start <= 1'b1;
            state     <= S_PERP;
          end
        end
        S_PERP: begin
          if (div_done) begin
            perp  <= (div_quot > DIV_NW'(PERP_SAT)) ? PERP_SAT : div_quot[23:0];
            state <= S_LH_GO;
          end
        end
        S_LH_GO: begin
          if (perp == 24'd0) begin
            lh    <= LH_SAT;
            state <= S_WALL;
          end else begin
            div_num   <= DIV_NW'({h_eff, {FRAC_BITS{1'b0}}});
            div_den   <= DIV_DW'(perp);
            div_start <= 1'b1;
            state     <= S_LH;
          end
        end
        S_LH: begin
          if (div_done) begin
            lh    <= (div_quot > DIV_NW'(LH_SAT)) ? LH_SAT : div_quot[15:0];
            state <= S_WALL;
          end
        end
        S_WALL: begin
          wprod <= {8'b0, perp} * r_oth[31:0];
          state <= S_FRAC;
        end
        S_FRAC: begin
          frac  <= p_oth + wprod[31:16];
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            res.out_column    <= column;
            res.perp_distance <= perp;
            res.line_height   <= lh;
            res.wall_top      <= ds_v;
            res.wall_bottom   <= de_v;
            res.hit_side      <= side;
            res.hit_cell      <= hit_byte;
            res.wall_fraction <= frac;
            res.escaped       <= esc;
            res_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/grid_dda_ray_caster.sv
`timescale 1ns / 1ps
// Grid ray caster over a 64 by 64 byte map. A write beat stores one map byte; a
// cast beat walks the grid for one screen column and returns one result beat. A cast takes
// five passes of the shared one-bit-per-cycle divider (camera offset, two delta distances,
// wall distance, line height; fewer when a ray component is zero or the ray escapes) plus,
// for each of up to 130 grid steps, a step state and an evaluate state that reads the map
// memory. After reset the map is cleared one byte a cycle, during which no command beat is
// taken; register writes are taken at any time but should change only while no cast is in
// flight.
module grid_dda_ray_caster (
  input  logic           clk,
  input  logic           rst,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  gdr_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output gdr_pkg::res_t  res
);
  import gdr_pkg::*;

  cfg_t   cfg;
  qhead_t head;
  logic   pop;
  logic   back_ready;
  logic   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.player_x       <= 22'd2129920;
      cfg.player_y       <= 22'd2129920;
      cfg.facing_x       <= -18'sd65536;
      cfg.facing_y       <= 18'sd0;
      cfg.camera_plane_x <= 18'sd0;
      cfg.camera_plane_y <= 18'sd43254;
      cfg.screen_width   <= 12'd640;
      cfg.screen_height  <= 12'd480;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_PLAYER_X:       cfg.player_x       <= pwdata[21:0];
        REG_PLAYER_Y:       cfg.player_y       <= pwdata[21:0];
        REG_FACING_X:       cfg.facing_x       <= $signed(pwdata[17:0]);
        REG_FACING_Y:       cfg.facing_y       <= $signed(pwdata[17:0]);
        REG_CAMERA_PLANE_X: cfg.camera_plane_x <= $signed(pwdata[17:0]);
        REG_CAMERA_PLANE_Y: cfg.camera_plane_y <= $signed(pwdata[17:0]);
        REG_SCREEN_WIDTH:   cfg.screen_width   <= pwdata[11:0];
        REG_SCREEN_HEIGHT:  cfg.screen_height  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_PLAYER_X:       prdata = {10'b0, cfg.player_x};
      REG_PLAYER_Y:       prdata = {10'b0, cfg.player_y};
      REG_FACING_X:       prdata = {14'b0, cfg.facing_x};
      REG_FACING_Y:       prdata = {14'b0, cfg.facing_y};
      REG_CAMERA_PLANE_X: prdata = {14'b0, cfg.camera_plane_x};
      REG_CAMERA_PLANE_Y: prdata = {14'b0, cfg.camera_plane_y};
      REG_SCREEN_WIDTH:   prdata = {20'b0, cfg.screen_width};
      REG_SCREEN_HEIGHT:  prdata = {20'b0, cfg.screen_height};
      default:            prdata = 32'd0;
    endcase
  end

  gdr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .back_ready (back_ready),
    .pop        (pop),
    .head       (head)
  );

  gdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .ready     (back_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

>>> tb/sv/grid_dda_ray_caster_tb.sv
`timescale 1ns / 1ps
module grid_dda_ray_caster_tb;
  import gdr_pkg::*;

  localparam longint ONE_Q = 64'sd65536;
  localparam longint DELTA_MAX = (64'sd1 <<< 40) - 1;
  localparam longint PERP_MAX = 64'sd16777215;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  res_t res;

  grid_dda_ray_caster dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cfg_t view;
  byte unsigned map_shadow [MAP_DEPTH];
  cmd_t pending_cmds [$];
  res_t wall_hits_due [$];
  int errors = 0;
  int n_casts = 0;
  int n_writes = 0;
  int n_escapes = 0;
  int n_zero_dist = 0;
  int n_checked = 0;

  function automatic longint delta_dist(longint r);
    longint a, d;
    a = (r < 0) ? -r : r;
    if (a == 0) return DELTA_MAX;
    d = (64'sd1 <<< 32) / a;
    return (d > DELTA_MAX) ? DELTA_MAX : d;
  endfunction

  function automatic longint scale_q(longint a, longint b);
    return (b >>> 16) * a + (((b & 64'sd65535) * a) >>> 16);
  endfunction

  function automatic res_t cast_ray(cmd_t c);
    longint x, w, h, cam, rx, ry, px, py, mx, my, dx, dy, stx, sty, sx, sy;
    longint perp, lh, frac, ds, de, num, rr, wall;
    int n;
    bit hit, esc, side;
    byte unsigned cell_byte;
    res_t r;
    hit = 0;
    esc = 0;
    side = 0;
    cell_byte = 0;
    frac = 0;
    x = longint'(c.column);
    w = (view.screen_width == 0) ? 1 : longint'(view.screen_width);
    h = (view.screen_height == 0) ? 1 : longint'(view.screen_height);
    cam = ((2 * x) <<< 16) / w - ONE_Q;
    rx = longint'($signed(view.facing_x)) + ((longint'($signed(view.camera_plane_x)) * cam) >>> 16);
    ry = longint'($signed(view.facing_y)) + ((longint'($signed(view.camera_plane_y)) * cam) >>> 16);
    px = longint'(view.player_x);
    py = longint'(view.player_y);
    mx = px >>> 16;
    my = py >>> 16;
    dx = delta_dist(rx);
    dy = delta_dist(ry);
    stx = (rx < 0) ? -1 : 1;
    sty = (ry < 0) ? -1 : 1;
    sx = scale_q((rx < 0) ? px - mx * ONE_Q : (mx + 1) * ONE_Q - px, dx);
    sy = scale_q((ry < 0) ? py - my * ONE_Q : (my + 1) * ONE_Q - py, dy);
    if (mx >= MAP_DIM || my >= MAP_DIM) esc = 1;
    for (n = 0; !esc && !hit && n < 2 * MAP_DIM + 2; n++) begin
      if (sx < sy) begin
        sx += dx;
        mx += stx;
        side = 0;
      end else begin
        sy += dy;
        my += sty;
        side = 1;
      end
      if (mx < 0 || mx >= MAP_DIM || my < 0 || my >= MAP_DIM) begin
        esc = 1;
      end else begin
        cell_byte = map_shadow[my * MAP_DIM + mx];
        if (cell_byte > WALL_LIMIT) hit = 1;
      end
    end
    if (!hit) esc = 1;
    if (esc) begin
      cell_byte = 0;
      perp = PERP_MAX;
      lh = 0;
    end else begin
      if (side == 0) begin
        num = mx * ONE_Q - px + ((stx < 0) ? ONE_Q : 0);
        rr = rx;
      end else begin
        num = my * ONE_Q - py + ((sty < 0) ? ONE_Q : 0);
        rr = ry;
      end
      if (rr == 0) begin
        perp = PERP_MAX;
      end else begin
        perp = (((num < 0) ? -num : num) <<< 16) / ((rr < 0) ? -rr : rr);
        if (perp > PERP_MAX) perp = PERP_MAX;
      end
      if (perp == 0) begin
        lh = 65535;
      end else begin
        lh = (h <<< 16) / perp;
        if (lh > 65535) lh = 65535;
      end
      if (side == 0) wall = py + ((perp * ry) >>> 16);
      else wall = px + ((perp * rx) >>> 16);
      frac = wall & (ONE_Q - 1);
    end
    ds = (h >>> 1) - ((lh + 1) >>> 1);
    if (ds < 0) ds = 0;
    if (ds > 2047) ds = 2047;
    de = (lh >>> 1) + (h >>> 1);
    if (de >= h) de = h - 1;
    if (de > 2047) de = 2047;
    r.out_column = 11'(x);
    r.perp_distance = 24'(perp);
    r.line_height = 16'(lh);
    r.wall_top = 11'(ds);
    r.wall_bottom = 11'(de);
    r.hit_side = side;
    r.hit_cell = cell_byte;
    r.wall_fraction = 16'(frac);
    r.escaped = esc;
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, field, got, want);
  endtask

  task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) report(field, got, want);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!(cmd_valid && cmd_stall)) begin
      if (cmd_valid) begin
        if (cmd.command == CMD_WRITE) begin
          map_shadow[{cmd.cell_row, cmd.cell_col}] = cmd.cell_value;
          n_writes++;
        end else begin
          wall_hits_due.push_back(cast_ray(cmd));
          n_casts++;
        end
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        cmd_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall behavior switches among free, light and heavy modes.
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (wall_hits_due.size() == 0) begin
        report("unexpected beat", 32'(res.out_column), 32'd0);
      end else begin
        res_t want;
        want = wall_hits_due.pop_front();
        n_checked++;
        if (want.escaped) n_escapes++;
        if (want.line_height == LH_SAT) n_zero_dist++;
        check_field("out_column", 32'(res.out_column), 32'(want.out_column));
        check_field("perp_distance", 32'(res.perp_distance), 32'(want.perp_distance));
        check_field("line_height", 32'(res.line_height), 32'(want.line_height));
        check_field("wall_top", 32'(res.wall_top), 32'(want.wall_top));
        check_field("wall_bottom", 32'(res.wall_bottom), 32'(want.wall_bottom));
        check_field("hit_side", 32'(res.hit_side), 32'(want.hit_side));
        check_field("hit_cell", 32'(res.hit_cell), 32'(want.hit_cell));
        check_field("wall_fraction", 32'(res.wall_fraction), 32'(want.wall_fraction));
        check_field("escaped", 32'(res.escaped), 32'(want.escaped));
      end
    end
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(50, 600);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 2) == 0);
        default: res_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_view(cfg_t c);
    write_reg(REG_PLAYER_X, 32'(c.player_x));
    write_reg(REG_PLAYER_Y, 32'(c.player_y));
    write_reg(REG_FACING_X, 32'(c.facing_x));
    write_reg(REG_FACING_Y, 32'(c.facing_y));
    write_reg(REG_CAMERA_PLANE_X, 32'(c.camera_plane_x));
    write_reg(REG_CAMERA_PLANE_Y, 32'(c.camera_plane_y));
    write_reg(REG_SCREEN_WIDTH, 32'(c.screen_width));
    write_reg(REG_SCREEN_HEIGHT, 32'(c.screen_height));
    view = c;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || cmd_valid || wall_hits_due.size() != 0)
      @(negedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic cmd_t cast_cmd(int col);
    cmd_t c;
    c = '0;
    c.command = CMD_CAST;
    c.column = 11'(col);
    return c;
  endfunction

  function automatic cmd_t write_cmd(int row, int col, int value);
    cmd_t c;
    c = '0;
    c.command = CMD_WRITE;
    c.cell_row = 6'(row);
    c.cell_col = 6'(col);
    c.cell_value = 8'(value);
    return c;
  endfunction

  function automatic cfg_t random_view(int k);
    cfg_t c;
    c.player_x = 22'($urandom_range(65536, 63 * 65536 - 1));
    c.player_y = 22'($urandom_range(65536, 63 * 65536 - 1));
    if ($urandom_range(0, 3) == 0) c.player_x[15:0] = '0;
    if ($urandom_range(0, 3) == 0) c.player_y[15:0] = '0;
    c.facing_x = 18'($urandom);
    c.facing_y = 18'($urandom);
    c.camera_plane_x = 18'($urandom);
    c.camera_plane_y = 18'($urandom);
    c.screen_width = 12'($urandom_range(1, 2048));
    c.screen_height = 12'($urandom_range(1, 2048));
    case (k)
      0: begin
        c.player_x = '0;
        c.player_y = '0;
        c.facing_x = 18'sh20000;
        c.facing_y = 18'sh20000;
        c.camera_plane_x = 18'sh20000;
        c.camera_plane_y = 18'sh20000;
        c.screen_width = 12'd1;
        c.screen_height = 12'd1;
      end
      1: begin
        c.player_x = '1;
        c.player_y = '1;
        c.facing_x = 18'sh1FFFF;
        c.facing_y = 18'sh1FFFF;
        c.camera_plane_x = 18'sh1FFFF;
        c.camera_plane_y = 18'sh1FFFF;
        c.screen_width = 12'd4095;
        c.screen_height = 12'd4095;
      end
      2: begin
        c.screen_width = 12'd2048;
        c.screen_height = 12'd2048;
      end
      default: ;
    endcase
    return c;
  endfunction

  task automatic random_items(int count);
    int weff;
    weff = (view.screen_width == 0) ? 1 : int'(view.screen_width);
    if (weff > 2048) weff = 2048;
    repeat (count) begin
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 3))
          0, 1: pending_cmds.push_back(write_cmd($urandom_range(1, 62), $urandom_range(1, 62),
                                                 $urandom_range(49, 255)));
          2: pending_cmds.push_back(write_cmd($urandom_range(0, 63), $urandom_range(0, 63),
                                              $urandom_range(0, 48)));
          default: pending_cmds.push_back(write_cmd($urandom_range(0, 63),
                                                    $urandom_range(0, 63), $urandom_range(0, 255)));
        endcase
      end else if ($urandom_range(0, 6) == 0) begin
        pending_cmds.push_back(cast_cmd($urandom_range(0, 2047)));
      end else begin
        pending_cmds.push_back(cast_cmd($urandom_range(0, weff - 1)));
      end
    end
  endtask

  initial begin
    cfg_t c;
    foreach (map_shadow[i]) map_shadow[i] = 0;
    view.player_x = 22'd2129920;
    view.player_y = 22'd2129920;
    view.facing_x = -18'sd65536;
    view.facing_y = 18'sd0;
    view.camera_plane_x = 18'sd0;
    view.camera_plane_y = 18'sd43254;
    view.screen_width = 12'd640;
    view.screen_height = 12'd480;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty-map rays escape, also past the screen width; then a cell of 48 is no wall but one of 49 is.
    pending_cmds.push_back(cast_cmd(0));
    pending_cmds.push_back(cast_cmd(639));
    pending_cmds.push_back(cast_cmd(2047));
    pending_cmds.push_back(write_cmd(0, 0, 0));
    pending_cmds.push_back(write_cmd(63, 63, 255));
    pending_cmds.push_back(write_cmd(32, 31, 48));
    pending_cmds.push_back(cast_cmd(320));
    pending_cmds.push_back(write_cmd(32, 31, 49));
    pending_cmds.push_back(cast_cmd(320));
    pending_cmds.push_back(cast_cmd(0));
    drain();

    // Player on a cell boundary next to a wall gives zero distance.
    c = view;
    c.player_x = 22'(32 * 65536);
    load_view(c);
    pending_cmds.push_back(cast_cmd(320));
    drain();

    // A zero x component of the ray, then zero screen sizes, then a tall screen.
    c.facing_x = '0;
    c.camera_plane_x = '0;
    load_view(c);
    pending_cmds.push_back(cast_cmd(320));
    pending_cmds.push_back(cast_cmd(0));
    drain();
    c.screen_width = '0;
    c.screen_height = '0;
    load_view(c);
    pending_cmds.push_back(cast_cmd(0));
    pending_cmds.push_back(cast_cmd(1));
    drain();
    c = view;
    c.player_x = 22'd2129920;
    c.facing_x = -18'sd65536;
    c.screen_width = 12'd640;
    c.screen_height = 12'd4095;
    load_view(c);
    pending_cmds.push_back(cast_cmd(320));
    pending_cmds.push_back(cast_cmd(5));
    drain();

    // Close the map with a wall on every border cell.
    for (int i = 0; i < MAP_DIM; i++) begin
      pending_cmds.push_back(write_cmd(0, i, $urandom_range(49, 255)));
      pending_cmds.push_back(write_cmd(63, i, $urandom_range(49, 255)));
      if (i != 0 && i != 63) begin
        pending_cmds.push_back(write_cmd(i, 0, $urandom_range(49, 255)));
        pending_cmds.push_back(write_cmd(i, 63, $urandom_range(49, 255)));
      end
    end
    random_items(40);
    drain();

    for (int k = 0; k < 8; k++) begin
      load_view(random_view(k));
      random_items(50);
      drain();
    end

    $display("Covered %0d casts and %0d map writes; %0d results checked.",
             n_casts, n_writes, n_checked);
    $display("Escaped rays: %0d, saturated line heights: %0d.", n_escapes, n_zero_dist);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
src/gdr_pkg.sv
src/gdr_ram.sv
src/gdr_divider.sv
src/gdr_front.sv
src/gdr_back.sv
src/grid_dda_ray_caster.sv
tb/sv/grid_dda_ray_caster_tb.sv
